// ----- rtl/core/mqtt_packet_framer_macros.svh -----
// ----------------------------------------------------------------------------
// mqtt_packet_framer_macros.svh
// Assertion helpers shared by the framer RTL.
// ----------------------------------------------------------------------------
`ifndef MQTT_PACKET_FRAMER_MACROS_SVH
`define MQTT_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication.
`define MPF_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/mpf_pkg.sv -----
// ----------------------------------------------------------------------------
// mpf_pkg
// Types and constants shared by the MQTT packet framer.
// ----------------------------------------------------------------------------
package mpf_pkg;

  localparam int CAP_W     = 29;
  localparam int ADDR_W    = 3;
  localparam int BYTES_MAX = 14;
  localparam int CNT_W     = 4;
  localparam int BODY_MAX  = 12;

  localparam logic [CAP_W-1:0] CAP_RESET = 29'd256;
  localparam logic [CAP_W-1:0] RL_LIMIT  = 29'h0FFF_FFFF;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  // register word index (paddr[2])
  localparam logic REG_OUT_CAPACITY = 1'b0;

  localparam logic [7:0] HDR_CONNECT   = 8'h10;
  localparam logic [7:0] HDR_PUBLISH   = 8'h30;
  localparam logic [7:0] HDR_SUBSCRIBE = 8'h82;
  localparam logic [7:0] HDR_PINGREQ   = 8'hC0;
  localparam logic [7:0] PROTO_LEVEL   = 8'h04;
  localparam logic [7:0] FLAG_CLEAN    = 8'h02;
  localparam logic [7:0] VARINT_MORE   = 8'h80;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_STRING  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_PAIR    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CONNECT   = 2'd0,
    KIND_PUBLISH   = 2'd1,
    KIND_SUBSCRIBE = 2'd2,
    KIND_PINGREQ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SIZE    = 2'd2,
    ST_STRAY   = 2'd3
  } status_t;

  localparam logic [1:0] QOS_INVALID = 2'd3;

  // capacity register plus values derived from it at write time
  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic [CAP_W-1:0] cap_m5;
    logic             cap_lt2;
    logic             cap_lt5;
    logic             cap_lt20;
  } cfg_t;

  // one queue entry: the bytes caused by one accepted word
  typedef struct packed {
    logic [BYTES_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      eop;
    status_t                   status;
  } job_t;

endpackage

// ----- rtl/core/mpf_in_if.sv -----
// ----------------------------------------------------------------------------
// mpf_in_if
// Request channel: start and data words into the framer.
// ----------------------------------------------------------------------------
interface mpf_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  packet_kind;
  logic [15:0] string_length;
  logic [27:0] payload_length;
  logic [1:0]  service_level;
  logic [15:0] keepalive_seconds;
  logic        clean_start;
  logic [15:0] message_id;
  logic [7:0]  data_byte;

  modport source (
    output valid, func, packet_kind, string_length, payload_length, service_level,
           keepalive_seconds, clean_start, message_id, data_byte,
    input  ready
  );
  modport sink (
    input  valid, func, packet_kind, string_length, payload_length, service_level,
           keepalive_seconds, clean_start, message_id, data_byte,
    output ready
  );
endinterface

// ----- rtl/core/mpf_out_if.sv -----
// ----------------------------------------------------------------------------
// mpf_out_if
// Byte channel: framed packet bytes out of the framer.
// ----------------------------------------------------------------------------
interface mpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_packet;
  logic [1:0] status;

  modport source (output valid, out_byte, end_of_packet, status, input ready);
  modport sink (input valid, out_byte, end_of_packet, status, output ready);
endinterface

// ----- rtl/core/mpf_front.sv -----
// ----------------------------------------------------------------------------
// mpf_front
// Accepts request words, checks them, tracks the open packet and builds
// the byte list for each word as one queue entry.
// ----------------------------------------------------------------------------
module mpf_front (
  input  logic          clk,
  input  logic          rst,
  mpf_in_if.sink        cmd,
  input  mpf_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          q_push,
  output mpf_pkg::job_t q_job
);
  import mpf_pkg::*;

  phase_t      phase, phase_next;
  kind_t       open_kind, open_kind_next;
  logic [15:0] sbl, sbl_next;
  logic [27:0] pbl, pbl_next;
  logic [1:0]  hsl, hsl_next;
  logic [15:0] hmid, hmid_next;

  logic        start;
  kind_t       kind;
  logic        qos_nz;
  logic        slen_z;
  logic        plen_nz;
  logic [CAP_W-1:0] var_len;
  logic        fits;
  status_t     start_status;
  logic [2:0]  rl_n;
  logic [3:0][7:0] rl_b;
  logic [15:0] sbl_dec;
  logic [27:0] pbl_dec;
  logic        str_done;
  logic        tail_pid;
  logic        to_payload;

  assign cmd.ready = !q_full;
  assign q_push    = cmd.valid && !q_full;

  assign start   = (cmd.func == FUNC_START);
  assign kind    = kind_t'(cmd.packet_kind);
  assign qos_nz  = (cmd.service_level != 2'd0);
  assign slen_z  = (cmd.string_length == 16'd0);
  assign plen_nz = (cmd.payload_length != 28'd0);

  // variable header + payload length of the requested packet
  always_comb begin
    unique case (kind)
      KIND_CONNECT:   var_len = CAP_W'(cmd.string_length) + CAP_W'(10);
      KIND_PUBLISH:   var_len = CAP_W'(cmd.string_length) + CAP_W'(cmd.payload_length)
                                + (qos_nz ? CAP_W'(4) : CAP_W'(2));
      KIND_SUBSCRIBE: var_len = CAP_W'(cmd.string_length) + CAP_W'(5);
      default:        var_len = '0;
    endcase
  end

  // rl <= 4 bytes, so var_len <= cap-5 also covers the whole-packet check
  assign fits = (var_len <= RL_LIMIT) && !cfg.cap_lt5 && (var_len <= cfg.cap_m5);

  always_comb begin
    priority if (kind == KIND_PINGREQ) begin
      start_status = cfg.cap_lt2 ? ST_SIZE : ST_OK;
    end else if (kind == KIND_CONNECT) begin
      start_status = (cfg.cap_lt20 || !fits) ? ST_SIZE : ST_OK;
    end else if (cmd.service_level == QOS_INVALID) begin
      start_status = ST_INVALID;
    end else if (cmd.message_id == 16'd0 && (kind == KIND_SUBSCRIBE || qos_nz)) begin
      start_status = ST_INVALID;
    end else if (!fits) begin
      start_status = ST_SIZE;
    end else begin
      start_status = ST_OK;
    end
  end

  // remaining-length varint
  always_comb begin
    if (var_len < CAP_W'(128))          rl_n = 3'd1;
    else if (var_len < CAP_W'(16384))   rl_n = 3'd2;
    else if (var_len < CAP_W'(2097152)) rl_n = 3'd3;
    else                                rl_n = 3'd4;
    rl_b[0] = {rl_n > 3'd1, var_len[6:0]};
    rl_b[1] = {rl_n > 3'd2, var_len[13:7]};
    rl_b[2] = {rl_n > 3'd3, var_len[20:14]};
    rl_b[3] = {1'b0, var_len[27:21]};
  end

  assign sbl_dec    = sbl - 16'd1;
  assign pbl_dec    = pbl - 28'd1;
  assign str_done   = (sbl_dec == 16'd0);
  assign tail_pid   = (open_kind == KIND_PUBLISH) && (hsl != 2'd0);
  assign to_payload = (open_kind == KIND_PUBLISH) && (pbl != 28'd0);

  // next state
  always_comb begin
    phase_next     = phase;
    open_kind_next = open_kind;
    sbl_next       = sbl;
    pbl_next       = pbl;
    hsl_next       = hsl;
    hmid_next      = hmid;
    if (!start) begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_PAYLOAD: begin
          pbl_next = pbl_dec;
          if (pbl_dec == 28'd0) phase_next = PH_IDLE;
        end
        PH_STRING, PH_PAIR: begin
          sbl_next   = sbl_dec;
          phase_next = PH_STRING;
          if (str_done) phase_next = to_payload ? PH_PAYLOAD : PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end else begin
      phase_next = PH_IDLE;
      if (start_status == ST_OK) begin
        unique case (kind)
          KIND_PINGREQ: begin
          end
          KIND_CONNECT: begin
            open_kind_next = KIND_CONNECT;
            pbl_next       = '0;
            sbl_next       = cmd.string_length;
            phase_next     = slen_z ? PH_IDLE : PH_PAIR;
          end
          default: begin
            open_kind_next = kind;
            hsl_next       = cmd.service_level;
            hmid_next      = cmd.message_id;
            sbl_next       = cmd.string_length;
            pbl_next       = (kind == KIND_PUBLISH) ? cmd.payload_length : 28'd0;
            if (!slen_z)                                phase_next = PH_STRING;
            else if (kind == KIND_PUBLISH && plen_nz)   phase_next = PH_PAYLOAD;
            else                                        phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // queue entry for this word
  always_comb begin
    logic [BODY_MAX-1:0][7:0] body;
    logic [CNT_W-1:0]         body_n;
    logic [7:0]               hdr;
    logic [CNT_W-1:0]         tail_at;
    logic [CNT_W-1:0]         j;
    body    = '0;
    body_n  = '0;
    hdr     = '0;
    tail_at = '0;
    j       = '0;
    q_job   = '0;
    q_job.status = ST_OK;
    if (!start) begin
      unique case (phase)
        PH_IDLE: begin
          q_job.count  = CNT_W'(1);
          q_job.eop    = 1'b1;
          q_job.status = ST_STRAY;
        end
        PH_PAYLOAD: begin
          q_job.bytes[0] = cmd.data_byte;
          q_job.count    = CNT_W'(1);
          q_job.eop      = (pbl_dec == 28'd0);
        end
        default: begin
          // string byte, with the length pair ahead of the first client-id byte
          if (phase == PH_PAIR) begin
            q_job.bytes[0] = sbl[15:8];
            q_job.bytes[1] = sbl[7:0];
            q_job.bytes[2] = cmd.data_byte;
            tail_at        = CNT_W'(3);
          end else begin
            q_job.bytes[0] = cmd.data_byte;
            tail_at        = CNT_W'(1);
          end
          q_job.count = tail_at;
          if (str_done) begin
            q_job.eop = !to_payload;
            if (tail_pid) begin
              q_job.bytes[tail_at]          = hmid[15:8];
              q_job.bytes[tail_at + 4'd1]   = hmid[7:0];
              q_job.count                   = tail_at + CNT_W'(2);
            end else if (open_kind == KIND_SUBSCRIBE) begin
              q_job.bytes[tail_at]          = {6'd0, hsl};
              q_job.count                   = tail_at + CNT_W'(1);
            end
          end
        end
      endcase
    end else if (start_status != ST_OK) begin
      q_job.count  = CNT_W'(1);
      q_job.eop    = 1'b1;
      q_job.status = start_status;
    end else if (kind == KIND_PINGREQ) begin
      q_job.bytes[0] = HDR_PINGREQ;
      q_job.bytes[1] = 8'h00;
      q_job.count    = CNT_W'(2);
      q_job.eop      = 1'b1;
    end else begin
      unique case (kind)
        KIND_CONNECT: begin
          hdr     = HDR_CONNECT;
          body[0] = 8'h00;
          body[1] = 8'h04;
          body[2] = 8'h4D;
          body[3] = 8'h51;
          body[4] = 8'h54;
          body[5] = 8'h54;
          body[6] = PROTO_LEVEL;
          body[7] = cmd.clean_start ? FLAG_CLEAN : 8'h00;
          body[8] = cmd.keepalive_seconds[15:8];
          body[9] = cmd.keepalive_seconds[7:0];
          // empty client id: its zero length pair closes the packet here
          body_n    = slen_z ? CNT_W'(12) : CNT_W'(10);
          q_job.eop = slen_z;
        end
        KIND_PUBLISH: begin
          hdr     = HDR_PUBLISH | {5'd0, cmd.service_level, 1'b0};
          body[0] = cmd.string_length[15:8];
          body[1] = cmd.string_length[7:0];
          body[2] = cmd.message_id[15:8];
          body[3] = cmd.message_id[7:0];
          body_n    = (slen_z && qos_nz) ? CNT_W'(4) : CNT_W'(2);
          q_job.eop = slen_z && !plen_nz;
        end
        default: begin
          hdr     = HDR_SUBSCRIBE;
          body[0] = cmd.message_id[15:8];
          body[1] = cmd.message_id[7:0];
          body[2] = cmd.string_length[15:8];
          body[3] = cmd.string_length[7:0];
          body[4] = {6'd0, cmd.service_level};
          body_n    = slen_z ? CNT_W'(5) : CNT_W'(4);
          q_job.eop = slen_z;
        end
      endcase
      // header byte, then varint, then body packed behind it
      q_job.bytes[0] = hdr;
      for (int i = 1; i < BYTES_MAX; i++) begin
        if (CNT_W'(i) <= CNT_W'(rl_n)) begin
          q_job.bytes[i] = rl_b[2'(i - 1)];
        end else begin
          j = CNT_W'(i) - CNT_W'(1) - CNT_W'(rl_n);
          if (j < CNT_W'(BODY_MAX)) q_job.bytes[i] = body[j];
        end
      end
      q_job.count = CNT_W'(1) + CNT_W'(rl_n) + body_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      open_kind <= KIND_CONNECT;
      sbl       <= '0;
      pbl       <= '0;
      hsl       <= '0;
      hmid      <= '0;
    end else if (q_push) begin
      phase     <= phase_next;
      open_kind <= open_kind_next;
      sbl       <= sbl_next;
      pbl       <= pbl_next;
      hsl       <= hsl_next;
      hmid      <= hmid_next;
    end
  end

endmodule

// ----- rtl/core/mpf_queue.sv -----
// ----------------------------------------------------------------------------
// mpf_queue
// Two-entry queue of byte lists between the front and the byte emitter.
// ----------------------------------------------------------------------------
module mpf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mpf_pkg::job_t push_job,
  input  logic          pop,
  output mpf_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import mpf_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/core/mpf_back.sv -----
// ----------------------------------------------------------------------------
// mpf_back
// Moves head entry bytes to the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module mpf_back (
  input  logic          clk,
  input  logic          rst,
  input  mpf_pkg::job_t head,
  input  logic          empty,
  output logic          pop,
  mpf_out_if.source     pkt
);
  import mpf_pkg::*;

  logic [CNT_W-1:0] idx;
  logic             load;
  logic             last;

  assign load = !pkt.valid || pkt.ready;
  assign last = (idx == head.count - CNT_W'(1));
  assign pop  = load && !empty && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt.valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      pkt.valid <= !empty;
      if (!empty) idx <= last ? '0 : idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      pkt.out_byte      <= head.bytes[idx];
      pkt.end_of_packet <= last && head.eop;
      pkt.status        <= head.status;
    end
  end

endmodule

// ----- rtl/core/mqtt_packet_framer.sv -----
// ----------------------------------------------------------------------------
// mqtt_packet_framer
// MQTT 3.1.1 CONNECT / PUBLISH / SUBSCRIBE / PINGREQ framer, byte stream out.
// ----------------------------------------------------------------------------
// Usage:
//  cmd : request words. func=0 opens a packet (kind, lengths, QoS, id,
//        keepalive, clean flag); func=1 carries one client-id/topic byte,
//        then one PUBLISH payload byte.
//  pkt : packet bytes with end_of_packet and status. A failed request or a
//        data word with no packet open gives one word: byte 0, eop, status.
//  APB : one register, out_capacity at address 0 (reset 256).
// Timing: a word is taken every cycle while the two-entry queue has room.
//  Its bytes go through a queue slot into the output register; the emitter
//  drains one byte per cycle while pkt.ready allows, so a start word (up to
//  14 bytes) holds the request side for its length; data words give 1-3 bytes.
// Stall: when pkt.ready is low the output register holds, the queue fills
//  and cmd.ready drops; nothing is lost or repeated.
// Reset: synchronous; clears the open packet, the queue and pkt.valid and
//  loads out_capacity with 256.
// ----------------------------------------------------------------------------
`include "mqtt_packet_framer_macros.svh"

module mqtt_packet_framer (
  input  logic                      clk,
  input  logic                      rst,
  mpf_in_if.sink                    cmd,
  mpf_out_if.source                 pkt,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mpf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import mpf_pkg::*;

  cfg_t cfg;
  logic cfg_wr;
  job_t q_job;
  job_t q_head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic [CAP_W-1:0] wdata;

  // --- register port: zero-wait APB, word select on paddr[2] ---
  assign pready = 1'b1;
  assign wdata  = pwdata[CAP_W-1:0];
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_OUT_CAPACITY);
  assign prdata = (paddr[2] == REG_OUT_CAPACITY) ? {{(32-CAP_W){1'b0}}, cfg.capacity}
                                                 : 32'd0;

  // compare results against the capacity are settled at write time so the
  // request checks only add and compare once
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity <= CAP_RESET;
      cfg.cap_m5   <= CAP_RESET - CAP_W'(5);
      cfg.cap_lt2  <= 1'b0;
      cfg.cap_lt5  <= 1'b0;
      cfg.cap_lt20 <= 1'b0;
    end else if (cfg_wr) begin
      cfg.capacity <= wdata;
      cfg.cap_m5   <= wdata - CAP_W'(5);
      cfg.cap_lt2  <= (wdata < CAP_W'(2));
      cfg.cap_lt5  <= (wdata < CAP_W'(5));
      cfg.cap_lt20 <= (wdata < CAP_W'(20));
    end
  end

  // --- front: check and expand request words ---
  mpf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  // --- decoupling queue ---
  mpf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // --- back: one byte per cycle into the output register unless stalled ---
  mpf_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .empty (q_empty),
    .pop   (q_pop),
    .pkt   (pkt)
  );

  `MPF_ASSERT_IMPLY(a_queue_no_overflow, clk, rst, q_push, !q_full, "push into full queue")
  `MPF_ASSERT_IMPLY(a_error_ends_packet, clk, rst, pkt.valid && pkt.status != ST_OK, pkt.end_of_packet, "error word without end_of_packet")
  `MPF_ASSERT_NEXT(a_cap_write, clk, rst, cfg_wr, cfg.capacity == $past(wdata) && cfg.cap_m5 == $past(wdata) - CAP_W'(5), "capacity register mismatch")

endmodule

// ----- tb/sv/mqtt_packet_framer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mqtt_packet_framer_checker
// Watches the request, byte and APB ports of the framer, builds the expected
// byte stream for every accepted request word and compares each accepted
// output word against it.
// ----------------------------------------------------------------------------
module mqtt_packet_framer_checker (
  input  logic                       clk,
  input  logic                       rst,
  mpf_in_if                          cmd,
  mpf_out_if                         pkt,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mpf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         mismatch_count,
  output int                         bytes_waiting,
  output int                         bytes_checked
);
  import mpf_pkg::*;

  localparam logic [31:0] PROTO_NAME = "MQTT";
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    status_t    st;
  } frame_byte_t;

  frame_byte_t frame_q[$];

  logic [CAP_W-1:0] capacity;
  phase_t           ph;
  kind_t            held_kind;
  logic [15:0]      str_left;
  logic [27:0]      pay_left;
  logic [1:0]       held_qos;
  logic [15:0]      held_id;
  int               n_bad;
  int               n_seen;

  function automatic longint unsigned varint_len(longint unsigned v);
    if (v < 128) return 1;
    if (v < 16384) return 2;
    if (v < 2097152) return 3;
    return 4;
  endfunction

  function automatic bit fits(longint unsigned vlen);
    longint unsigned cap64;
    cap64 = 64'(capacity);
    if (vlen > RL_LIMIT) return 1'b0;
    if (cap64 < 5 || vlen > cap64 - 5) return 1'b0;
    return (1 + varint_len(vlen) + vlen) <= cap64;
  endfunction

  task automatic push_byte(input logic [7:0] b, inout int n);
    frame_q.push_back('{data: b, eop: 1'b0, st: ST_OK});
    n++;
  endtask

  task automatic push_error(input status_t s);
    ph = PH_IDLE;
    frame_q.push_back('{data: 8'h00, eop: 1'b1, st: s});
  endtask

  task automatic close_frame(input int n);
    frame_byte_t last;
    ph = PH_IDLE;
    if (n > 0) begin
      last = frame_q.pop_back();
      last.eop = 1'b1;
      frame_q.push_back(last);
    end
  endtask

  task automatic push_varint(input longint unsigned v, inout int n);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b = b | VARINT_MORE;
      push_byte(b, n);
    end while (v != 0);
  endtask

  // tail of the variable header once the last string byte is out
  task automatic after_string(inout int n);
    if (held_kind == KIND_PUBLISH) begin
      if (held_qos != 2'd0) begin
        push_byte(held_id[15:8], n);
        push_byte(held_id[7:0], n);
      end
      if (pay_left != 0) begin
        ph = PH_PAYLOAD;
        return;
      end
    end else if (held_kind == KIND_SUBSCRIBE) begin
      push_byte({6'd0, held_qos}, n);
    end
    close_frame(n);
  endtask

  task automatic frame_word(input logic fn, input kind_t k, input logic [15:0] sl,
                            input logic [27:0] pl, input logic [1:0] q,
                            input logic [15:0] ka, input logic cl,
                            input logic [15:0] id, input logic [7:0] db);
    int              n;
    longint unsigned vlen;
    n = 0;
    if (fn == FUNC_DATA) begin
      if (ph == PH_IDLE) begin
        push_error(ST_STRAY);
      end else if (ph == PH_PAYLOAD) begin
        push_byte(db, n);
        pay_left = pay_left - 28'd1;
        if (pay_left == 0) close_frame(n);
      end else begin
        // client-id length pair rides ahead of the first id byte
        if (ph == PH_PAIR) begin
          push_byte(str_left[15:8], n);
          push_byte(str_left[7:0], n);
          ph = PH_STRING;
        end
        push_byte(db, n);
        str_left = str_left - 16'd1;
        if (str_left == 0) after_string(n);
      end
      return;
    end

    ph = PH_IDLE;
    if (k == KIND_PINGREQ) begin
      if (capacity < 2) begin
        push_error(ST_SIZE);
      end else begin
        push_byte(HDR_PINGREQ, n);
        push_byte(8'h00, n);
        close_frame(n);
      end
    end else if (k == KIND_CONNECT) begin
      vlen = 10 + longint'(sl);
      if (capacity < 20 || !fits(vlen)) begin
        push_error(ST_SIZE);
      end else begin
        push_byte(HDR_CONNECT, n);
        push_varint(vlen, n);
        push_byte(8'h00, n);
        push_byte(8'h04, n);
        push_byte(PROTO_NAME[31:24], n);
        push_byte(PROTO_NAME[23:16], n);
        push_byte(PROTO_NAME[15:8], n);
        push_byte(PROTO_NAME[7:0], n);
        push_byte(PROTO_LEVEL, n);
        push_byte(cl ? FLAG_CLEAN : 8'h00, n);
        push_byte(ka[15:8], n);
        push_byte(ka[7:0], n);
        held_kind = KIND_CONNECT;
        pay_left = '0;
        str_left = sl;
        if (sl == 0) begin
          push_byte(8'h00, n);
          push_byte(8'h00, n);
          close_frame(n);
        end else begin
          ph = PH_PAIR;
        end
      end
    end else if (q == QOS_INVALID) begin
      push_error(ST_INVALID);
    end else if (id == 0 && (k == KIND_SUBSCRIBE || q != 2'd0)) begin
      push_error(ST_INVALID);
    end else begin
      if (k == KIND_PUBLISH)
        vlen = 2 + longint'(sl) + longint'(pl) + ((q != 2'd0) ? 2 : 0);
      else
        vlen = 5 + longint'(sl);
      if (!fits(vlen)) begin
        push_error(ST_SIZE);
      end else begin
        if (k == KIND_PUBLISH) begin
          push_byte(HDR_PUBLISH | {5'd0, q, 1'b0}, n);
          push_varint(vlen, n);
          push_byte(sl[15:8], n);
          push_byte(sl[7:0], n);
          pay_left = pl;
        end else begin
          push_byte(HDR_SUBSCRIBE, n);
          push_varint(vlen, n);
          push_byte(id[15:8], n);
          push_byte(id[7:0], n);
          push_byte(sl[15:8], n);
          push_byte(sl[7:0], n);
          pay_left = '0;
        end
        held_kind = k;
        held_qos = q;
        held_id = id;
        str_left = sl;
        if (sl == 0) after_string(n);
        else ph = PH_STRING;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      capacity  = CAP_RESET;
      ph        = PH_IDLE;
      held_kind = KIND_CONNECT;
      str_left  = '0;
      pay_left  = '0;
      held_qos  = '0;
      held_id   = '0;
      n_bad     = 0;
      n_seen    = 0;
      frame_q.delete();
    end else begin
      // output side first: a word accepted now cannot show up this edge
      if (pkt.valid && pkt.ready) begin
        frame_byte_t want;
        n_seen++;
        if (frame_q.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_MAX)
            $display("%0t: unexpected output word data %02h eop %0b status %0d",
                     $realtime, pkt.out_byte, pkt.end_of_packet, pkt.status);
        end else begin
          want = frame_q.pop_front();
          if (pkt.out_byte !== want.data || pkt.end_of_packet !== want.eop ||
              pkt.status !== want.st) begin
            n_bad++;
            if (n_bad <= REPORT_MAX)
              $display("%0t: output mismatch, expected %02h/%0b/%0d got %02h/%0b/%0d",
                       $realtime, want.data, want.eop, want.st,
                       pkt.out_byte, pkt.end_of_packet, pkt.status);
          end
        end
      end
      if (cmd.valid && cmd.ready)
        frame_word(cmd.func, kind_t'(cmd.packet_kind), cmd.string_length,
                   cmd.payload_length, cmd.service_level, cmd.keepalive_seconds,
                   cmd.clean_start, cmd.message_id, cmd.data_byte);
      if (psel && penable && pwrite && pready && paddr[2] == REG_OUT_CAPACITY)
        capacity = pwdata[CAP_W-1:0];
    end
    mismatch_count <= n_bad;
    bytes_waiting  <= frame_q.size();
    bytes_checked  <= n_seen;
  end

endmodule

// ----- tb/sv/tb_mqtt_packet_framer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mqtt_packet_framer
// Drives request words and capacity writes into the MQTT framer, throttles
// the byte output at random, and lets the checker predict and compare every
// framed byte. Directed packets first, then random phases per capacity.
// ----------------------------------------------------------------------------
module tb_mqtt_packet_framer;
  import mpf_pkg::*;

  localparam int NUM_PHASES = 9;
  localparam int HOLD_CYCLES = 300;   // long output stall, fills the queue
  localparam int SETTLE_CYCLES = 8;   // beyond the queue and output register

  // capacity per random phase; phase 0 runs on the reset value
  localparam logic [31:0] CAP_PLAN [NUM_PHASES] = '{
    32'd256, 32'd20, 32'd19, 32'hFFFF_FFFF, 32'd0, 32'd4, 32'd5, 32'd48, 32'd256
  };
  // request words per random phase (tiny capacities give errors, at most PINGREQ fits)
  localparam int WORD_PLAN [NUM_PHASES] = '{34, 20, 14, 42, 10, 10, 10, 38, 47};

  localparam logic [ADDR_W-1:0] CAP_ADDR = {REG_OUT_CAPACITY, 2'b00};

  typedef struct packed {
    logic        func;
    kind_t       kind;
    logic [15:0] sl;
    logic [27:0] pl;
    logic [1:0]  q;
    logic [15:0] ka;
    logic        cl;
    logic [15:0] id;
    logic [7:0]  db;
  } cmd_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int mismatches;
  int waiting;
  int checked;
  int words_sent = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  bit calm = 1'b0;         // no idling on either side while set

  mpf_in_if  cmd_ch();
  mpf_out_if pkt_ch();

  mqtt_packet_framer i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .pkt     (pkt_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mqtt_packet_framer_checker i_chk (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_ch),
    .pkt            (pkt_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatches),
    .bytes_waiting  (waiting),
    .bytes_checked  (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop: far above the slowest legal run, the long stall included.
  initial begin
    #3_000_000;
    $display("mqtt_packet_framer test failed");
    $finish;
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  // The hold is counted here so the sender keeps offering words meanwhile.
  initial begin
    pkt_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pkt_ch.ready <= 1'b0;
      end else if (calm) begin
        pkt_ch.ready <= 1'b1;
      end else begin
        pkt_ch.ready <= ($urandom_range(99) >= 13);
      end
    end
  end

  function automatic cmd_word_t start_word(kind_t k, logic [15:0] sl, logic [27:0] pl,
                                           logic [1:0] q, logic [15:0] id);
    cmd_word_t w;
    w.func = FUNC_START;
    w.kind = k;
    w.sl   = sl;
    w.pl   = pl;
    w.q    = q;
    w.id   = id;
    w.ka   = 16'($urandom);
    w.cl   = 1'($urandom);
    w.db   = 8'($urandom);   // ignored on a start word
    return w;
  endfunction

  // data word; every field but the byte is ignored, so it is noise
  function automatic cmd_word_t data_word(logic [7:0] b);
    cmd_word_t w;
    w = start_word(kind_t'($urandom_range(3)), 16'($urandom), 28'($urandom),
                   2'($urandom), 16'($urandom));
    w.func = FUNC_DATA;
    w.db   = b;
    return w;
  endfunction

  // Offer one word and hold it until accepted. Always entered right after
  // a rising edge; valid gets a single nonblocking write per step.
  task automatic send_word(input cmd_word_t w);
    if (!calm && $urandom_range(99) < 13) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid             <= 1'b1;
    cmd_ch.func              <= w.func;
    cmd_ch.packet_kind       <= w.kind;
    cmd_ch.string_length     <= w.sl;
    cmd_ch.payload_length    <= w.pl;
    cmd_ch.service_level     <= w.q;
    cmd_ch.keepalive_seconds <= w.ka;
    cmd_ch.clean_start       <= w.cl;
    cmd_ch.message_id        <= w.id;
    cmd_ch.data_byte         <= w.db;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Data words a well-formed packet of this shape takes.
  function automatic int body_len(kind_t k, int sl, int pl);
    if (k == KIND_PINGREQ) return 0;
    if (k == KIND_PUBLISH) return sl + pl;
    return sl;
  endfunction

  // Start word followed by nd data words (fewer than the body truncates it).
  task automatic send_packet(input kind_t k, input int sl, input int pl,
                             input logic [1:0] q, input logic [15:0] id, input int nd);
    send_word(start_word(k, 16'(sl), 28'(pl), q, id));
    repeat (nd) send_word(data_word(8'($urandom)));
  endtask

  // Stop offering, wait for every expected byte, then let the pipe empty.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random traffic: mostly complete packets with random content, the rest
  // truncated packets, out-of-range arguments and stray data words.
  task automatic random_words(input int target);
    int    r;
    int    sl;
    int    pl;
    int    body;
    kind_t k;
    while (words_sent < target) begin
      r = $urandom_range(99);
      k = kind_t'($urandom_range(3));
      sl = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(6);
      pl = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
      body = body_len(k, sl, pl);
      if (r < 65) begin
        send_packet(k, sl, pl, 2'($urandom_range(2)), 16'($urandom_range(65535, 1)), body);
      end else if (r < 77) begin
        // cut short; the next start word drops it
        send_packet(k, sl, pl, 2'($urandom_range(2)), 16'($urandom_range(65535, 1)),
                    (body > 0) ? $urandom_range(body - 1) : 0);
      end else if (r < 89) begin
        // full-range lengths, any QoS, sometimes a zero packet id
        send_packet(k, $urandom_range(65535), $urandom & 28'h0FFF_FFFF,
                    2'($urandom_range(3)), ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom),
                    $urandom_range(3));
      end else begin
        repeat ($urandom_range(3, 1)) send_word(data_word(8'($urandom)));
      end
    end
  endtask

  initial begin
    int target;
    cmd_ch.valid             = 1'b0;
    cmd_ch.func              = FUNC_START;
    cmd_ch.packet_kind       = KIND_CONNECT;
    cmd_ch.string_length     = '0;
    cmd_ch.payload_length    = '0;
    cmd_ch.service_level     = '0;
    cmd_ch.keepalive_seconds = '0;
    cmd_ch.clean_start       = 1'b0;
    cmd_ch.message_id        = '0;
    cmd_ch.data_byte         = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, capacity 256 -------------------------------------------
    send_packet(KIND_PINGREQ, 0, 0, 2'd0, 16'd0, 0);
    send_packet(KIND_CONNECT, 0, 0, 2'd0, 16'd0, 0);        // id pair ends start burst
    send_packet(KIND_CONNECT, 2, 0, 2'd0, 16'd0, 2);        // id pair on first data word
    send_packet(KIND_PUBLISH, 1, 2, 2'd0, 16'd0, 3);        // QoS 0 needs no id
    send_packet(KIND_PUBLISH, 0, 0, 2'd1, 16'hFFFF, 0);     // closes on the start word
    send_packet(KIND_PUBLISH, 1, 1, 2'd2, 16'd1, 2);
    send_packet(KIND_SUBSCRIBE, 1, 0, 2'd2, 16'h8001, 1);
    send_packet(KIND_PUBLISH, 1, 0, QOS_INVALID, 16'd7, 0); // invalid QoS
    send_packet(KIND_SUBSCRIBE, 1, 0, 2'd0, 16'd0, 0);      // zero id on subscribe
    send_packet(KIND_PUBLISH, 1, 0, 2'd1, 16'd0, 0);        // zero id with QoS 1
    send_word(data_word(8'hFF));                            // nothing open
    send_packet(KIND_PUBLISH, 3, 0, 2'd0, 16'd0, 1);        // left open ...
    send_packet(KIND_CONNECT, 16'hFFFF, 0, 2'd0, 16'd0, 0); // ... dropped, then too big
    send_packet(KIND_PUBLISH, 16'hFFFF, 28'h0FFF_FFFF, 2'd2, 16'hFFFF, 0); // over limit
    send_packet(KIND_SUBSCRIBE, 200, 0, 2'd1, 16'd5, 0);    // two-byte length, dropped
    send_packet(KIND_PINGREQ, 0, 0, 2'd0, 16'd0, 0);

    // --- random phases, one capacity each -----------------------------------
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        settle();                  // sender waits for every byte before a write
        apb_write(CAP_ADDR, CAP_PLAN[p]);
        @(posedge clk);
      end
      calm = (p == 7);
      if (p == 0) hold_requests++;  // long output stall with input still offered
      if (p == 3) begin
        // full capacity: three- and four-byte remaining length, limit edge
        send_packet(KIND_PUBLISH, 0, 20000, 2'd0, 16'd1, 0);
        send_packet(KIND_PUBLISH, 0, 28'h0FFF_FFFD, 2'd0, 16'd1, 2);
        send_packet(KIND_PUBLISH, 0, 28'h0FFF_FFFE, 2'd0, 16'd1, 0);
        send_packet(KIND_CONNECT, 16'hFFFF, 0, 2'd0, 16'd0, 1);
      end
      target = words_sent + WORD_PLAN[p];
      random_words(target);
    end

    // --- drain and verdict ---------------------------------------------------
    calm = 1'b0;
    settle();
    repeat (20) @(posedge clk);
    $display("Run covered %0d request words and %0d framed bytes over %0d capacity settings,",
             words_sent, checked, NUM_PHASES);
    $display("  all packet kinds, argument/size errors, stray and truncated words, long stall.");
    if (mismatches == 0 && waiting == 0) begin
      $display("mqtt_packet_framer test passed");
    end else begin
      $display("mqtt_packet_framer test failed");
    end
    $finish;
  end

endmodule
